// ===== src/average_true_range_defines.svh =====
// assertion macros for the average true range block
// used by the top level only, no other dependencies
`ifndef AVERAGE_TRUE_RANGE_DEFINES_SVH
`define AVERAGE_TRUE_RANGE_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define ATR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define ATR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/atr_pkg.sv =====
// shared constants and types for the average true range block
// no dependencies
`default_nettype none

package atr_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int PRICE_BITS = 32;

  localparam int FieldW  = 32;
  localparam int PriceW  = (PRICE_BITS < FieldW) ? PRICE_BITS : FieldW;
  localparam int WinRegW = 7;
  localparam logic [WinRegW-1:0] WinReset = 7'd14;
  localparam int CountW  = $clog2(MAX_WINDOW + 1);
  localparam int PtrW    = $clog2(MAX_WINDOW);
  localparam int SumW    = PriceW + $clog2(MAX_WINDOW);
  localparam int FracW   = 8;
  localparam int NumW    = SumW + FracW;
  localparam int DivCntW = $clog2(NumW + 1);
  localparam int AvgW    = 40;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam int DataW = 32;
  localparam int AddrW = 3;
  localparam logic [AddrW-3:0] RegWindowIdx = '0;

  typedef struct packed {
    logic              first;
    logic [PriceW-1:0] tr;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== src/atr_channels.sv =====
// valid/ready channels for price bars and average results
// depends on atr_pkg
`default_nettype none

interface atr_bar_if import atr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              start_series;
  logic [FieldW-1:0] high_price;
  logic [FieldW-1:0] low_price;
  logic [FieldW-1:0] close_price;

  modport source (output valid, start_series, high_price, low_price, close_price,
                  input ready);
  modport sink   (input valid, start_series, high_price, low_price, close_price,
                  output ready);
endinterface

interface atr_avg_if import atr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [AvgW-1:0] range_average;
  logic            average_valid;

  modport source (output valid, range_average, average_valid, input ready);
  modport sink   (input valid, range_average, average_valid, output ready);
endinterface

`default_nettype wire

// ===== src/average_true_range.sv =====
// Average true range over a sliding window of price bars. Bars enter on the
// bar channel, one mean true range per bar leaves on the average channel in
// ticks with 8 fraction bits. A front stage forms the true range and queues
// it; the back stage stores it in a 64-entry ring, sums the last window
// entries through the ring's single read port (one per cycle) and divides
// with a one-bit-per-cycle restoring divider over the 46-bit scaled sum.
// A bar that opens a series goes to the result register with a zero average;
// any other bar is summed over look entries and then divided, where look =
// min(window, ranges so far). No clearing pass runs after reset.
// Register at byte address 0: window_length (7 bits, reset 14); the window
// should only be written while no bar is in flight.
// depends on atr_pkg, atr_channels, atr_front, atr_queue, atr_back
`default_nettype none

`include "average_true_range_defines.svh"

module average_true_range import atr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  atr_bar_if.sink               bar_i,
  atr_avg_if.source             avg_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic [DataW-1:0]      prdata,
  output logic                  pready
);

  logic [WinRegW-1:0] win_q;
  logic               win_sel, cfg_wr;
  logic               q_push, q_pop;
  cmd_t               q_in, q_out;
  q_stat_t            q_stat;

  assign pready  = 1'b1;
  assign win_sel = (paddr[AddrW-1:2] == RegWindowIdx);
  assign cfg_wr  = psel && penable && pwrite && pready && win_sel;
  assign prdata  = win_sel ? {{(DataW - WinRegW){1'b0}}, win_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WinReset;
    end else if (cfg_wr) begin
      win_q <= pwdata[WinRegW-1:0];
    end
  end

  atr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .bar_i    (bar_i),
    .q_stat_i (q_stat),
    .push_o   (q_push),
    .cmd_o    (q_in)
  );

  atr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_in),
    .pop_i  (q_pop),
    .cmd_o  (q_out),
    .stat_o (q_stat)
  );

  atr_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .win_i    (win_q),
    .q_stat_i (q_stat),
    .cmd_i    (q_out),
    .pop_o    (q_pop),
    .avg_o    (avg_o)
  );

  `ATR_ASSERT(a_no_underflow, !(q_pop && q_stat.empty), "queue popped while empty")
  `ATR_ASSERT(a_first_zero, !(avg_o.valid && !avg_o.average_valid && (avg_o.range_average != '0)), "series start beat carries a nonzero average")
  `ATR_ASSERT_NEXT(a_win_write, cfg_wr, win_q == $past(pwdata[WinRegW-1:0]), "window write lost")

endmodule

`default_nettype wire

// ===== src/atr_front.sv =====
// front end: accepts bars, tracks the previous close, forms the true range
// depends on atr_pkg and atr_channels
`default_nettype none

module atr_front import atr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  atr_bar_if.sink      bar_i,
  input  wire q_stat_t q_stat_i,
  output logic         push_o,
  output cmd_t         cmd_o
);

  logic [PriceW-1:0] prev_close_q, prev_close_d;
  logic              have_prev_q, have_prev_d;
  logic [PriceW-1:0] hi, lo, cl, span, gap_hi, gap_lo;

  function automatic logic [PriceW-1:0] gap(input logic [PriceW-1:0] a,
                                            input logic [PriceW-1:0] b);
    gap = (a >= b) ? a - b : b - a;
  endfunction

  assign hi = bar_i.high_price[PriceW-1:0];
  assign lo = bar_i.low_price[PriceW-1:0];
  assign cl = bar_i.close_price[PriceW-1:0];

  assign bar_i.ready = !q_stat_i.full;
  assign push_o      = bar_i.valid && bar_i.ready;

  always_comb begin
    span   = (hi >= lo) ? hi - lo : '0;
    gap_hi = gap(hi, prev_close_q);
    gap_lo = gap(lo, prev_close_q);
    cmd_o.first = bar_i.start_series || !have_prev_q;
    cmd_o.tr    = span;
    if (gap_hi > cmd_o.tr) cmd_o.tr = gap_hi;
    if (gap_lo > cmd_o.tr) cmd_o.tr = gap_lo;
  end

  always_comb begin
    prev_close_d = prev_close_q;
    have_prev_d  = have_prev_q;
    if (push_o) begin
      prev_close_d = cl;
      have_prev_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_close_q <= '0;
      have_prev_q  <= 1'b0;
    end else begin
      prev_close_q <= prev_close_d;
      have_prev_q  <= have_prev_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/atr_queue.sv =====
// short command queue between front and back
// depends on atr_pkg
`default_nettype none

module atr_queue import atr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output cmd_t      cmd_o,
  output q_stat_t   stat_o
);

  cmd_t             slot_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  function automatic logic [QPtrW-1:0] inc(input logic [QPtrW-1:0] p);
    inc = (p == QPtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat_o.full  = (cnt_q == QCntW'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign cmd_o        = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= inc(rd_ptr_q);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/atr_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on atr_pkg
`default_nettype none

module atr_div import atr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [NumW-1:0]   dividend_i,
  input  wire logic [CountW-1:0] divisor_i,
  output logic                   done_o,
  output logic [NumW-1:0]        quotient_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [NumW-1:0]    dq_q;
  logic [CountW-1:0]  rem_q;
  logic [CountW-1:0]  dvs_q;
  logic [CountW:0]    shifted, diff;
  logic               take;

  // remainder stays below the divisor, so it fits the divisor width
  always_comb begin
    shifted = {rem_q, dq_q[NumW-1]};
    diff    = shifted - {1'b0, dvs_q};
    take    = (shifted >= {1'b0, dvs_q});
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[NumW-2:0], take};
      rem_q <= take ? diff[CountW-1:0] : shifted[CountW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/atr_back.sv =====
// back end: true range ring, window sum sweep, division, result register
// depends on atr_pkg, atr_channels and atr_div
`default_nettype none

module atr_back import atr_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [WinRegW-1:0] win_i,
  input  wire q_stat_t            q_stat_i,
  input  wire cmd_t               cmd_i,
  output logic                    pop_o,
  atr_avg_if.source               avg_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [CountW-1:0] count_q;
  logic [PtrW-1:0]   ptr_q;
  logic [PtrW-1:0]   addr_q;
  logic [CountW-1:0] left_q;
  logic [CountW-1:0] look_q;
  logic [SumW-1:0]   sum_q;
  logic              rd_vld_q;
  logic              zero_q;
  logic              out_vld_q;
  logic [AvgW-1:0]   out_avg_q;
  logic              out_ok_q;

  logic [PriceW-1:0] ring_mem [MAX_WINDOW];
  logic [PriceW-1:0] rd_data_q;

  logic              wr_en, rd_en, div_start, div_done, load_out;
  logic [CountW-1:0] win, count_new, look;
  logic [PtrW-1:0]   ptr_next, addr_prev;
  logic [NumW-1:0]   quotient;

  always_comb begin
    if (win_i == '0) begin
      win = CountW'(1);
    end else if (32'(win_i) > MAX_WINDOW) begin
      win = CountW'(MAX_WINDOW);
    end else begin
      win = CountW'(win_i);
    end
    count_new = (32'(count_q) < MAX_WINDOW) ? count_q + 1'b1 : count_q;
    look      = (win < count_new) ? win : count_new;
    ptr_next  = (ptr_q == PtrW'(MAX_WINDOW - 1)) ? '0 : ptr_q + 1'b1;
    addr_prev = (addr_q == '0) ? PtrW'(MAX_WINDOW - 1) : addr_q - 1'b1;
  end

  assign pop_o     = (state_q == ST_IDLE) && !q_stat_i.empty;
  assign wr_en     = pop_o && !cmd_i.first;
  assign rd_en     = (state_q == ST_SUM) && (left_q != '0);
  assign div_start = (state_q == ST_SUM) && (left_q == '0) && !rd_vld_q;
  // result register takes a new beat when empty or when its beat leaves
  assign load_out  = (state_q == ST_DONE) && (!out_vld_q || avg_o.ready);

  // newest range goes in first, the sweep then reads it back with the rest
  always_ff @(posedge clk_i) begin
    if (wr_en) ring_mem[ptr_q] <= cmd_i.tr;
    if (rd_en) rd_data_q <= ring_mem[addr_q];
  end

  atr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_q, {FracW{1'b0}}}),
    .divisor_i  (look_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign avg_o.valid         = out_vld_q;
  assign avg_o.range_average = out_avg_q;
  assign avg_o.average_valid = out_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      ptr_q     <= '0;
      addr_q    <= '0;
      left_q    <= '0;
      look_q    <= '0;
      sum_q     <= '0;
      rd_vld_q  <= 1'b0;
      zero_q    <= 1'b0;
      out_vld_q <= 1'b0;
      out_avg_q <= '0;
      out_ok_q  <= 1'b0;
    end else begin
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (avg_o.valid && avg_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            if (cmd_i.first) begin
              count_q <= '0;
              ptr_q   <= '0;
              sum_q   <= '0;
              zero_q  <= 1'b1;
              state_q <= ST_DONE;
            end else begin
              count_q  <= count_new;
              ptr_q    <= ptr_next;
              addr_q   <= ptr_q;
              left_q   <= look;
              look_q   <= look;
              sum_q    <= '0;
              rd_vld_q <= 1'b0;
              zero_q   <= 1'b0;
              state_q  <= ST_SUM;
            end
          end
        end
        ST_SUM: begin
          if (left_q != '0) begin
            addr_q   <= addr_prev;
            left_q   <= left_q - 1'b1;
            rd_vld_q <= 1'b1;
          end else begin
            rd_vld_q <= 1'b0;
          end
          if (rd_vld_q) sum_q <= sum_q + SumW'(rd_data_q);
          if (div_start) state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) begin
            out_avg_q <= zero_q ? '0 : AvgW'(quotient);
            out_ok_q  <= !zero_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
